@@ hdl/rlss_pkg.sv @@
// Shared types, constants and helper functions for the seven-bit LED strip serializer.
// This package has no dependencies. Every module of the block imports it.
package rlss_pkg;

    // These are the serial frame constants. Each channel goes out as a marker bit
    // followed by seven value bits.
    localparam int PIXEL_BITS  = 24;
    localparam int CHAN_BITS   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam logic [7:0] BRIGHT_RESET = 8'd255;
    localparam logic       MARKER_BIT   = 1'b1;

    // This is the pixel as it arrives on the input channel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_last;
    } t_pixel;

    // This is one serial bit as it leaves on the output channel.
    typedef struct packed {
        logic data_bit;
        logic run_last;
    } t_result;

    // This is a fully formatted pixel word as it is queued between front and back.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] bits;
        logic                  frame_last;
    } t_word;

    // This divides a 16-bit product by 255 exactly, using the reciprocal
    // identity x/255 = (x + 1 + (x >> 8)) >> 8 for x below 65535.
    function automatic logic [7:0] div255(input logic [15:0] prod);
        logic [16:0] sum;
        sum = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
        return sum[15:8];
    endfunction

    // This builds the channel byte: the marker, then bits 7 down to 1.
    function automatic logic [7:0] chan_byte(input logic [7:0] scaled);
        return {MARKER_BIT, scaled[7:1]};
    endfunction

endpackage

@@ hdl/rlss_front.sv @@
// This is the front end. It accepts pixels, scales them by brightness and formats the serial word.
// It depends on rlss_pkg and feeds rlss_queue.
module rlss_front
    import rlss_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_pixel i_pixel,
    output logic   o_word_valid,
    input  logic   i_word_ready,
    output t_word  o_word
);

    logic        r_valid;
    logic [7:0]  r_bright;
    logic [15:0] r_prod_r;
    logic [15:0] r_prod_g;
    logic [15:0] r_prod_b;
    logic        r_last;
    logic        accept;

    // A new pixel may enter whenever the product stage is empty or draining.
    assign o_ready = !r_valid || i_word_ready;
    assign accept  = i_valid && o_ready;

    // These are the brightness register and the stage-valid control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= BRIGHT_RESET;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bright <= i_cfg_data;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_word_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // The products are registered so the divide by 255 sits in the next stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_r <= 16'(i_pixel.red)   * 16'(r_bright);
            r_prod_g <= 16'(i_pixel.green) * 16'(r_bright);
            r_prod_b <= 16'(i_pixel.blue)  * 16'(r_bright);
            r_last   <= i_pixel.frame_last;
        end
    end

    // The word is formatted in green, red, blue order, each channel with its marker.
    always_comb begin
        o_word_valid      = r_valid;
        o_word.bits       = {chan_byte(div255(r_prod_g)),
                             chan_byte(div255(r_prod_r)),
                             chan_byte(div255(r_prod_b))};
        o_word.frame_last = r_last;
    end

endmodule

@@ hdl/rlss_queue.sv @@
// This is a short queue of formatted pixel words between the front end and the serializer.
// It depends on rlss_pkg.
module rlss_queue
    import rlss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_word i_push_word,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_word o_pop_word
);

    t_word               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_word   = r_mem[r_rd_ptr];

    // These are the pointers and the fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // This is the storage write.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

`ifndef SYNTH
    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // An empty queue stays empty when nothing is written.
    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && !push) |=> (r_count == '0))
        else $error("queue filled without a write");
`endif

endmodule

@@ hdl/rlss_back.sv @@
// This is the back end. It serializes words one bit per cycle unless stalled, with latch bits at frame end.
// It depends on rlss_pkg and drives the registered output channel.
module rlss_back
    import rlss_pkg::*;
#(
    parameter int LATCH_BYTES = 3
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_word_valid,
    output logic    o_word_ready,
    input  t_word   i_word,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int LATCH_BITS = LATCH_BYTES * 8;
    localparam int CNT_W      = $clog2(PIXEL_BITS + LATCH_BITS + 1);

    logic [PIXEL_BITS-1:0] r_shift;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid;
    t_result               r_out;
    logic                  emit;
    logic                  load;

    // One bit leaves whenever bits are owed and the output register is free or draining.
    assign emit         = (r_cnt != '0) && (!r_out_valid || i_ready);
    assign load         = i_word_valid && ((r_cnt == '0) || (emit && r_cnt == CNT_W'(1)));
    assign o_word_ready = (r_cnt == '0) || (emit && r_cnt == CNT_W'(1));
    assign o_valid      = r_out_valid;
    assign o_result     = r_out;

    // The bit counter and the output valid are control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_cnt <= i_word.frame_last ? CNT_W'(PIXEL_BITS + LATCH_BITS)
                                           : CNT_W'(PIXEL_BITS);
            end else if (emit) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The shifter fills with zeros, so the latch bits come out as zeros by themselves.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_shift <= i_word.bits;
        end else if (emit) begin
            r_shift <= {r_shift[PIXEL_BITS-2:0], 1'b0};
        end
        if (emit) begin
            r_out.data_bit <= r_shift[PIXEL_BITS-1];
            r_out.run_last <= (r_cnt == CNT_W'(1));
        end
    end

`ifndef SYNTH
    // A new word is taken only when the previous one has drained or is sending its final bit.
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (r_cnt == '0 || r_cnt == CNT_W'(1)))
        else $error("word loaded while bits still owed");

    // The final bit of a run is marked on the output register.
    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_cnt == CNT_W'(1)) |=> (r_out_valid && r_out.run_last))
        else $error("run end not flagged");

    // Latch bits are zero on the line.
    a_latch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_cnt <= CNT_W'(LATCH_BITS) && r_cnt != '0 && r_shift == '0)
            |=> !r_out.data_bit)
        else $error("nonzero bit during latch");
`endif

endmodule

@@ hdl/rgb_led_strip_seven_bit_serializer.sv @@
// A pixel passes the product register, the queue and the shifter before its first bit is output.
// The output carries one serial bit per cycle unless i_ready stalls it: 24 data bits per pixel,
// plus 8*LATCH_BYTES latch bits when frame_last is set; the back-end shifter sets that pace.
// A two-entry queue and the product stage let up to three pixels be taken ahead.
// Reset is synchronous and active low; it empties every stage and sets brightness to 255.
module rgb_led_strip_seven_bit_serializer
    import rlss_pkg::*;
#(
    parameter int LATCH_BYTES = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_pixel     i_pixel,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_result
);

    logic  front_valid;
    logic  front_ready;
    t_word front_word;
    logic  q_valid;
    logic  q_ready;
    t_word q_word;

    // The front end scales and formats each pixel.
    rlss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .o_word_valid (front_valid),
        .i_word_ready (front_ready),
        .o_word       (front_word)
    );

    // The queue decouples formatting from serializing.
    rlss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_word  (front_word),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_word   (q_word)
    );

    // The back end shifts out data bits and latch bits.
    rlss_back #(
        .LATCH_BYTES (LATCH_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (q_valid),
        .o_word_ready (q_ready),
        .i_word       (q_word),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (o_result)
    );

endmodule
